// ===== sv/bkra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkra_pkg: shared types, constants and key map for the keyboard report decoder
// Holds the command codes, the queue entry type, the back-end states and the
// usage-code to ASCII lookup.
// ----------------------------------------------------------------------------
package bkra_pkg;

    localparam int FIFO_DEPTH_DEFAULT = 64;
    localparam int KEY_SLOTS          = 6;
    localparam int SLOT_W             = $clog2(KEY_SLOTS);
    localparam int Q_DEPTH            = 2;

    localparam logic [1:0] CMD_REPORT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_SET    = 2'd2;

    localparam logic [6:0] MIN_REPORT     = 7'd8;
    localparam logic [7:0] USAGE_NONE     = 8'h00;
    localparam logic [7:0] USAGE_ROLLOVER = 8'h01;
    localparam logic [7:0] CAPS_USAGE     = 8'h39;
    localparam logic [7:0] LETTER_FIRST   = 8'h04;
    localparam logic [7:0] LETTER_LAST    = 8'h1D;
    localparam logic [7:0] MAP_SIZE       = 8'd128;
    localparam logic [7:0] SHIFT_MASK     = 8'h22;
    localparam logic [7:0] CAPS_LED       = 8'h02;

    typedef enum logic [1:0] {
        K_REPORT,
        K_READ,
        K_SET,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t                       kind;
        logic [7:0]                  mods;
        logic [KEY_SLOTS-1:0][7:0]   keys;
        logic [7:0]                  led;
    } entry_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SLOT,
        B_READ,
        B_EMIT
    } back_state_t;

    // Usage code to ASCII; codes without a character give zero.
    function automatic logic [6:0] key_to_ascii(input logic [7:0] code, input logic up);
        logic [6:0] c;
        c = 7'h00;
        if (code >= MAP_SIZE) begin
            c = 7'h00;
        end
        else if (code inside {[LETTER_FIRST:LETTER_LAST]}) begin
            c = up ? 7'(code + 8'h3D) : 7'(code + 8'h5D);
        end
        else if (!up && (code inside {[8'h1E:8'h26]})) begin
            c = 7'(code + 8'h13);
        end
        else if (code inside {[8'h59:8'h61]}) begin
            c = 7'(code - 8'h28);
        end
        else begin
            case (code)
                8'h1E: c = 7'h21;
                8'h1F: c = 7'h40;
                8'h20: c = 7'h23;
                8'h21: c = 7'h24;
                8'h22: c = 7'h25;
                8'h23: c = 7'h5E;
                8'h24: c = 7'h26;
                8'h25: c = 7'h2A;
                8'h26: c = 7'h28;
                8'h27: c = up ? 7'h29 : 7'h30;
                8'h28: c = 7'h0A;
                8'h29: c = 7'h1B;
                8'h2A: c = 7'h08;
                8'h2B: c = 7'h09;
                8'h2C: c = 7'h20;
                8'h2D: c = up ? 7'h5F : 7'h2D;
                8'h2E: c = up ? 7'h2B : 7'h3D;
                8'h2F: c = up ? 7'h7B : 7'h5B;
                8'h30: c = up ? 7'h7D : 7'h5D;
                8'h31: c = up ? 7'h7C : 7'h5C;
                8'h33: c = up ? 7'h3A : 7'h3B;
                8'h34: c = up ? 7'h22 : 7'h27;
                8'h35: c = up ? 7'h7E : 7'h60;
                8'h36: c = up ? 7'h3C : 7'h2C;
                8'h37: c = up ? 7'h3E : 7'h2E;
                8'h38: c = up ? 7'h3F : 7'h2F;
                8'h54: c = 7'h2F;
                8'h55: c = 7'h2A;
                8'h56: c = 7'h2D;
                8'h57: c = 7'h2B;
                8'h58: c = 7'h0A;
                8'h62: c = 7'h30;
                8'h63: c = 7'h2E;
                default: c = 7'h00;
            endcase
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== sv/bkra_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkra_if: request and response channels of the keyboard report decoder
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bkra_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [6:0] report_length;
    logic [7:0] modifier_bits;
    logic [7:0] key_0;
    logic [7:0] key_1;
    logic [7:0] key_2;
    logic [7:0] key_3;
    logic [7:0] key_4;
    logic [7:0] key_5;
    logic [7:0] led_value;

    modport source (
        output valid, command, report_length, modifier_bits,
               key_0, key_1, key_2, key_3, key_4, key_5, led_value,
        input  ready
    );
    modport sink (
        input  valid, command, report_length, modifier_bits,
               key_0, key_1, key_2, key_3, key_4, key_5, led_value,
        output ready
    );
endinterface

interface bkra_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] read_char;
    logic       char_valid;
    logic       data_available;
    logic [7:0] led_state;
    logic [7:0] current_modifiers;
    logic       char_dropped;

    modport source (
        output valid, read_char, char_valid, data_available, led_state,
               current_modifiers, char_dropped,
        input  ready
    );
    modport sink (
        input  valid, read_char, char_valid, data_available, led_state,
               current_modifiers, char_dropped,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/bkra_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkra_front: request classifier
// Sort each request into report, read, LED set or no-op and pack it for the
// command queue.
// ----------------------------------------------------------------------------
module bkra_front (
    bkra_req_if.sink            request,
    output logic                push_valid,
    input  logic                push_ready,
    output bkra_pkg::entry_t    push_data
);
    import bkra_pkg::*;

    kind_t kind;

    always_comb
    begin
        case (request.command)
            CMD_REPORT: kind = (request.report_length >= MIN_REPORT) ? K_REPORT : K_NOP;
            CMD_READ:   kind = K_READ;
            CMD_SET:    kind = K_SET;
            default:    kind = K_NOP;
        endcase
    end

    assign push_valid        = request.valid;
    assign request.ready     = push_ready;
    assign push_data.kind    = kind;
    assign push_data.mods    = request.modifier_bits;
    assign push_data.keys[0] = request.key_0;
    assign push_data.keys[1] = request.key_1;
    assign push_data.keys[2] = request.key_2;
    assign push_data.keys[3] = request.key_3;
    assign push_data.keys[4] = request.key_4;
    assign push_data.keys[5] = request.key_5;
    assign push_data.led     = request.led_value;

endmodule
`default_nettype wire

// ===== sv/bkra_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkra_queue: two-entry command queue
// Decouple the classifier from the slot sequencer.
// ----------------------------------------------------------------------------
module bkra_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  bkra_pkg::entry_t    push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output bkra_pkg::entry_t    pop_data
);
    import bkra_pkg::*;

    localparam int IDX_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    entry_t             entry_reg [Q_DEPTH];
    logic [IDX_W-1:0]   wr_idx_reg;
    logic [IDX_W-1:0]   wr_idx_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_idx_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_idx_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_idx_next = (wr_idx_reg == IDX_W'(Q_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_idx_next = (rd_idx_reg == IDX_W'(Q_DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_idx_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/bkra_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkra_back: slot sequencer, character FIFO and response register
// Walk the key slots of a report one per cycle, push characters into the
// ring FIFO, serve reads and LED writes, and register the response.
// ----------------------------------------------------------------------------
module bkra_back #(
    parameter int FIFO_DEPTH = bkra_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  bkra_pkg::entry_t    pop_data,
    bkra_rsp_if.source          response
);
    import bkra_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    back_state_t                state_reg;
    back_state_t                state_next;
    logic [SLOT_W-1:0]          slot_reg;
    logic [KEY_SLOTS-1:0][7:0]  keys_reg;
    logic [KEY_SLOTS-1:0][7:0]  prev_keys_reg;
    logic [7:0]                 led_reg;
    logic [7:0]                 mods_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_inc;
    logic [PTR_W-1:0]           wr_ptr_inc;
    logic [6:0]                 mem [FIFO_DEPTH];
    logic [6:0]                 mem_rdata_reg;
    logic [6:0]                 rc_reg;
    logic                       char_valid_reg;
    logic                       dropped_reg;
    logic                       out_valid_reg;
    logic [6:0]                 out_char_reg;
    logic                       out_char_valid_reg;
    logic                       out_avail_reg;
    logic [7:0]                 out_led_reg;
    logic [7:0]                 out_mods_reg;
    logic                       out_dropped_reg;

    logic       out_free;
    logic       take;
    logic       slot_go;
    logic       read_go;
    logic       emit;
    logic       last_slot;
    logic [7:0] cur_key;
    logic       seen;
    logic       new_key;
    logic       up;
    logic [6:0] ch;
    logic       full;
    logic       fifo_empty;
    logic       mem_we;
    logic       drop_hit;
    logic       caps_hit;

    assign out_free   = !out_valid_reg || response.ready;
    assign last_slot  = (slot_reg == SLOT_W'(KEY_SLOTS - 1));
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign full       = (wr_ptr_inc == rd_ptr_reg);
    assign fifo_empty = (rd_ptr_reg == wr_ptr_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    case (pop_data.kind)
                        K_REPORT: state_next = B_SLOT;
                        K_READ:   state_next = B_READ;
                        default:  state_next = B_EMIT;
                    endcase
                end
            end
            B_SLOT:  state_next = last_slot ? B_EMIT : B_SLOT;
            B_READ:  state_next = B_EMIT;
            B_EMIT:  state_next = out_free ? B_IDLE : B_EMIT;
            default: state_next = B_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        pop_ready = 1'b0;
        slot_go   = 1'b0;
        read_go   = 1'b0;
        emit      = 1'b0;
        case (state_reg)
            B_IDLE:  pop_ready = 1'b1;
            B_SLOT:  slot_go   = 1'b1;
            B_READ:  read_go   = 1'b1;
            B_EMIT:  emit      = out_free;
            default: pop_ready = 1'b0;
        endcase
    end

    assign take = pop_valid && pop_ready;

    // Slot datapath: compare against every key of the last report at once
    always_comb
    begin
        cur_key = keys_reg[slot_reg];
        seen    = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++)
        begin
            if (prev_keys_reg[j] == cur_key)
            begin
                seen = 1'b1;
            end
        end
        new_key = !(cur_key inside {USAGE_NONE, USAGE_ROLLOVER}) && !seen;
        up      = ((mods_reg & SHIFT_MASK) != '0)
                  ^ ((cur_key inside {[LETTER_FIRST:LETTER_LAST]})
                     && ((led_reg & CAPS_LED) != '0));
        ch      = key_to_ascii(cur_key, up);
    end

    assign mem_we   = slot_go && new_key && (ch != '0) && !full;
    assign drop_hit = slot_go && new_key && (ch != '0) && full;
    assign caps_hit = slot_go && new_key && (cur_key == CAPS_USAGE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            slot_reg      <= '0;
            prev_keys_reg <= '0;
            led_reg       <= '0;
            mods_reg      <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                slot_reg <= '0;
                if (pop_data.kind == K_REPORT)
                begin
                    mods_reg <= pop_data.mods;
                end
                if (pop_data.kind == K_SET)
                begin
                    led_reg <= pop_data.led;
                end
            end
            if (slot_go)
            begin
                slot_reg <= slot_reg + 1'b1;
                if (last_slot)
                begin
                    prev_keys_reg <= keys_reg;
                end
            end
            if (caps_hit)
            begin
                led_reg <= led_reg ^ CAPS_LED;
            end
            if (mem_we)
            begin
                wr_ptr_reg <= wr_ptr_inc;
            end
            if (read_go && !fifo_empty)
            begin
                rd_ptr_reg <= rd_ptr_inc;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Character memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= ch;
        end
        mem_rdata_reg <= mem[rd_ptr_reg];
    end

    // Work and response payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            keys_reg       <= pop_data.keys;
            rc_reg         <= '0;
            char_valid_reg <= 1'b0;
            dropped_reg    <= 1'b0;
        end
        if (drop_hit)
        begin
            dropped_reg <= 1'b1;
        end
        if (read_go && !fifo_empty)
        begin
            rc_reg         <= mem_rdata_reg;
            char_valid_reg <= 1'b1;
        end
        if (emit)
        begin
            out_char_reg       <= rc_reg;
            out_char_valid_reg <= char_valid_reg;
            out_avail_reg      <= !fifo_empty;
            out_led_reg        <= led_reg;
            out_mods_reg       <= mods_reg;
            out_dropped_reg    <= dropped_reg;
        end
    end

    assign response.valid             = out_valid_reg;
    assign response.read_char         = out_char_reg;
    assign response.char_valid        = out_char_valid_reg;
    assign response.data_available    = out_avail_reg;
    assign response.led_state         = out_led_reg;
    assign response.current_modifiers = out_mods_reg;
    assign response.char_dropped      = out_dropped_reg;

`ifndef SYNTHESIS
    a_push_leaves_data: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (rd_ptr_reg != wr_ptr_reg))
        else $error("FIFO empty right after a push");

    a_popped_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_char_valid_reg) |-> (out_char_reg != '0))
        else $error("popped character is zero");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SLOT) |-> (slot_reg <= SLOT_W'(KEY_SLOTS - 1)))
        else $error("slot index out of range");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == B_EMIT) && !out_free) |=> (state_reg == B_EMIT))
        else $error("response lost while output stalled");
`endif

endmodule
`default_nettype wire

// ===== sv/boot_keyboard_report_to_ascii_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// boot_keyboard_report_to_ascii_unit: boot keyboard report to ASCII decoder
// Decodes keyboard reports into characters held in a ring FIFO.
// ----------------------------------------------------------------------------
// Usage:
//   request carries one command per item: a keyboard report (modifier byte and
//   six key slots), a read of one queued character, or an LED byte write.
//   response returns exactly one item per request: the character read, FIFO
//   status, LED byte, latched modifiers and a drop flag.
// Flow:
//   A report leaves the command queue, then the slot sequencer handles one
//   slot a cycle (so that every slot may write the character memory), then
//   the response is registered. A read passes through the registered memory
//   read first; an LED write, a short report or an unused command goes
//   straight to the response register.
//   The sequencer takes a new item only once the last one has reached the
//   response register; a two-entry command queue lets the next request in
//   while one is decoded.
// Reset:
//   Clear LEDs, modifiers, previous keys and FIFO pointers; the FIFO is empty.
// Backpressure:
//   A stalled response holds its item; the sequencer waits, then the queue
//   fills and request.ready drops.
// ----------------------------------------------------------------------------
module boot_keyboard_report_to_ascii_unit #(
    parameter int FIFO_DEPTH = bkra_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bkra_req_if.sink    request,
    bkra_rsp_if.source  response
);
    import bkra_pkg::*;

    // Classified commands from front to queue
    logic   push_valid;
    logic   push_ready;
    entry_t push_data;

    // Queue head toward the slot sequencer
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_data;

    bkra_front u_front (
        .request    (request),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bkra_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Sequencer, character memory and response register
    bkra_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .response   (response)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_boot_keyboard_report_to_ascii_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_boot_keyboard_report_to_ascii_unit: self-checking bench for the decoder
// Drives keyboard reports, character reads and LED writes through the request
// channel, predicts every response from a private copy of the decoder state
// and compares each response field by field, in order, with random stalls on
// both channels.
// ----------------------------------------------------------------------------
module tb_boot_keyboard_report_to_ascii_unit;
    import bkra_pkg::*;

    // Command code that the block does not use; it reports status only.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int FIFO_SLOTS       = FIFO_DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS     = 1380;
    localparam int CALM_ITEMS       = 200;
    localparam int LONG_HOLD_AT     = 400;
    localparam int DRAIN_AT         = 700;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 20;
    localparam int REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [1:0]                command;
        logic [6:0]                report_length;
        logic [7:0]                modifier_bits;
        logic [KEY_SLOTS-1:0][7:0] keys;
        logic [7:0]                led_value;
    } cmd_item_t;

    typedef struct packed {
        logic [6:0] read_char;
        logic       char_valid;
        logic       data_available;
        logic [7:0] led_state;
        logic [7:0] current_modifiers;
        logic       char_dropped;
    } reply_t;

    // ------------------------------------------------------------------------
    // Tracks the decoder state (previous keys, character ring, LEDs, latched
    // modifiers) and holds the replies still owed by the block, oldest first.
    // ------------------------------------------------------------------------
    class char_queue_tracker;
        logic [7:0] last_keys [KEY_SLOTS];
        logic [6:0] char_ring [FIFO_SLOTS];
        int         rd_ptr;
        int         wr_ptr;
        logic [7:0] leds;
        logic [7:0] mods_latch;
        reply_t     awaited [$];
        int         mismatches;

        function new();
            foreach (last_keys[s]) last_keys[s] = USAGE_NONE;
            foreach (char_ring[s]) char_ring[s] = 7'h00;
            rd_ptr     = 0;
            wr_ptr     = 0;
            leds       = 8'h00;
            mods_latch = 8'h00;
            mismatches = 0;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        // Apply one accepted command to the tracked state; queue its reply.
        function void note_command(cmd_item_t it);
            reply_t     r;
            logic [7:0] code;
            logic [7:0] ch;
            logic       up;
            logic       held;
            int         nxt;
            r = '0;
            case (it.command)
                CMD_REPORT:
                begin
                    if (it.report_length >= MIN_REPORT)
                    begin
                        mods_latch = it.modifier_bits;
                        for (int s = 0; s < KEY_SLOTS; s++)
                        begin
                            code = it.keys[s];
                            if (code == USAGE_NONE || code == USAGE_ROLLOVER)
                                continue;
                            held = 1'b0;
                            foreach (last_keys[j])
                                if (last_keys[j] == code)
                                    held = 1'b1;
                            if (held)
                                continue;
                            // Look the usage code up; caps lock flips shift for letters.
                            up = |(it.modifier_bits & SHIFT_MASK);
                            ch = 8'h00;
                            if (code >= LETTER_FIRST && code <= LETTER_LAST)
                            begin
                                if (|(leds & CAPS_LED))
                                    up = !up;
                                ch = (up ? 8'h41 : 8'h61) + (code - LETTER_FIRST);
                            end
                            else if (code < MAP_SIZE)
                            begin
                                case (code)
                                    8'h1E: ch = up ? "!" : "1";
                                    8'h1F: ch = up ? "@" : "2";
                                    8'h20: ch = up ? "#" : "3";
                                    8'h21: ch = up ? "$" : "4";
                                    8'h22: ch = up ? "%" : "5";
                                    8'h23: ch = up ? "^" : "6";
                                    8'h24: ch = up ? "&" : "7";
                                    8'h25: ch = up ? "*" : "8";
                                    8'h26: ch = up ? "(" : "9";
                                    8'h27: ch = up ? ")" : "0";
                                    8'h28: ch = 8'h0A;
                                    8'h29: ch = 8'h1B;
                                    8'h2A: ch = 8'h08;
                                    8'h2B: ch = 8'h09;
                                    8'h2C: ch = " ";
                                    8'h2D: ch = up ? "_" : "-";
                                    8'h2E: ch = up ? "+" : "=";
                                    8'h2F: ch = up ? "{" : "[";
                                    8'h30: ch = up ? "}" : "]";
                                    8'h31: ch = up ? "|" : 8'h5C;
                                    8'h33: ch = up ? ":" : ";";
                                    8'h34: ch = up ? 8'h22 : "'";
                                    8'h35: ch = up ? "~" : 8'h60;
                                    8'h36: ch = up ? "<" : ",";
                                    8'h37: ch = up ? ">" : ".";
                                    8'h38: ch = up ? "?" : "/";
                                    8'h54: ch = "/";
                                    8'h55: ch = "*";
                                    8'h56: ch = "-";
                                    8'h57: ch = "+";
                                    8'h58: ch = 8'h0A;
                                    8'h62: ch = "0";
                                    8'h63: ch = ".";
                                    default:
                                    begin
                                        // keypad digits 1..9
                                        if (code >= 8'h59 && code <= 8'h61)
                                            ch = 8'h31 + (code - 8'h59);
                                    end
                                endcase
                            end
                            // Queue the character; the ring keeps one slot empty.
                            if (ch != 8'h00)
                            begin
                                nxt = (wr_ptr + 1) % FIFO_SLOTS;
                                if (nxt == rd_ptr)
                                    r.char_dropped = 1'b1;
                                else
                                begin
                                    char_ring[wr_ptr] = ch[6:0];
                                    wr_ptr = nxt;
                                end
                            end
                            if (code == CAPS_USAGE)
                                leds = leds ^ CAPS_LED;
                        end
                        foreach (last_keys[s]) last_keys[s] = it.keys[s];
                    end
                end
                CMD_READ:
                begin
                    if (rd_ptr != wr_ptr)
                    begin
                        r.read_char  = char_ring[rd_ptr];
                        r.char_valid = 1'b1;
                        rd_ptr = (rd_ptr + 1) % FIFO_SLOTS;
                    end
                end
                CMD_SET:
                    leds = it.led_value;
                default:
                    ;
            endcase
            r.data_available    = (rd_ptr != wr_ptr);
            r.led_state         = leds;
            r.current_modifiers = mods_latch;
            awaited.push_back(r);
        endfunction

        // Compare one response with the oldest reply still owed.
        function void check_reply(reply_t got);
            reply_t exp;
            logic   bad;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: response with nothing owed: char=%h cv=%b da=%b led=%h mod=%h drop=%b",
                             $realtime, got.read_char, got.char_valid, got.data_available,
                             got.led_state, got.current_modifiers, got.char_dropped);
                return;
            end
            exp = awaited.pop_front();
            bad = (got.read_char !== exp.read_char)
               || (got.char_valid !== exp.char_valid)
               || (got.data_available !== exp.data_available)
               || (got.led_state !== exp.led_state)
               || (got.current_modifiers !== exp.current_modifiers)
               || (got.char_dropped !== exp.char_dropped);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: response mismatch: expected char=%h cv=%b da=%b led=%h mod=%h drop=%b, got char=%h cv=%b da=%b led=%h mod=%h drop=%b",
                             $realtime, exp.read_char, exp.char_valid, exp.data_available,
                             exp.led_state, exp.current_modifiers, exp.char_dropped,
                             got.read_char, got.char_valid, got.data_available,
                             got.led_state, got.current_modifiers, got.char_dropped);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    bkra_req_if req_ch ();
    bkra_rsp_if rsp_ch ();

    boot_keyboard_report_to_ascii_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    always #6 clk = ~clk;

    char_queue_tracker tracker;

    // calm: no idling on either side; set for the last stretch of the run.
    logic       calm;
    // long_hold_req: ask the receiver for one long hold-off.
    logic       long_hold_req;
    // Keys last sent in a well-formed report, so that some stay held down.
    logic [7:0] held_keys [KEY_SLOTS];

    // Build a request item from its fields.
    function automatic cmd_item_t make_item(logic [1:0] command, logic [6:0] len,
                                            logic [7:0] mods, logic [7:0] k0,
                                            logic [7:0] k1, logic [7:0] k2,
                                            logic [7:0] k3, logic [7:0] k4,
                                            logic [7:0] k5, logic [7:0] led);
        cmd_item_t it;
        it.command       = command;
        it.report_length = len;
        it.modifier_bits = mods;
        it.keys[0]       = k0;
        it.keys[1]       = k1;
        it.keys[2]       = k2;
        it.keys[3]       = k3;
        it.keys[4]       = k4;
        it.keys[5]       = k5;
        it.led_value     = led;
        return it;
    endfunction

    // Draw one random item. Most reports mimic typing: a few keys, some held
    // over from the last report, zero padding. Alternate read-heavy and
    // report-heavy stretches so the FIFO both drains and overflows.
    function automatic cmd_item_t random_item(int idx);
        cmd_item_t it;
        int        pick;
        int        read_pct;
        int        n;
        int        sel;
        // Fill every field with noise first; unused fields must be ignored.
        it.command       = CMD_REPORT;
        it.report_length = 7'($urandom_range(0, 127));
        it.modifier_bits = 8'($urandom);
        foreach (it.keys[s]) it.keys[s] = 8'($urandom);
        it.led_value     = 8'($urandom);
        read_pct = ((idx / 120) % 2 == 0) ? 50 : 15;
        pick     = $urandom_range(0, 99);
        if (pick < read_pct)
            it.command = CMD_READ;
        else if (pick < read_pct + 8)
            it.command = CMD_SET;
        else if (pick < read_pct + 11)
            it.command = CMD_UNUSED;
        else if (pick < read_pct + 16)
            it.report_length = 7'($urandom_range(0, 7));    // short report
        else if (pick < read_pct + 20)
            ;                                               // noise report
        else
        begin
            it.report_length = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(8, 64)) : MIN_REPORT;
            case ($urandom_range(0, 5))
                0: it.modifier_bits = 8'h00;
                1: it.modifier_bits = 8'h02;
                2: it.modifier_bits = 8'h20;
                3: it.modifier_bits = 8'h22;
                default: it.modifier_bits = 8'($urandom);
            endcase
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, KEY_SLOTS) : $urandom_range(0, 3);
            for (int s = 0; s < KEY_SLOTS; s++)
            begin
                if (s >= n)
                    it.keys[s] = USAGE_NONE;
                else if (held_keys[s] != USAGE_NONE && $urandom_range(0, 2) == 0)
                    it.keys[s] = held_keys[s];
                else
                begin
                    sel = $urandom_range(0, 19);
                    if (sel == 0)
                        it.keys[s] = CAPS_USAGE;
                    else if (sel == 1)
                        it.keys[s] = 8'($urandom_range(8'h54, 8'h63));
                    else if (sel == 2)
                        it.keys[s] = 8'($urandom_range(8'h3A, 8'h7F));
                    else
                        it.keys[s] = 8'($urandom_range(LETTER_FIRST, 8'h38));
                end
            end
            // Phantom state: the keyboard reports rollover in every slot.
            if ($urandom_range(0, 19) == 0)
                foreach (it.keys[s]) it.keys[s] = USAGE_ROLLOVER;
            foreach (held_keys[s]) held_keys[s] = it.keys[s];
        end
        return it;
    endfunction

    // Offer one item at the falling edge, hold it until accepted, then note it.
    task automatic offer(input cmd_item_t it);
        @(negedge clk);
        req_ch.valid         <= 1'b1;
        req_ch.command       <= it.command;
        req_ch.report_length <= it.report_length;
        req_ch.modifier_bits <= it.modifier_bits;
        req_ch.key_0         <= it.keys[0];
        req_ch.key_1         <= it.keys[1];
        req_ch.key_2         <= it.keys[2];
        req_ch.key_3         <= it.keys[3];
        req_ch.key_4         <= it.keys[4];
        req_ch.key_5         <= it.keys[5];
        req_ch.led_value     <= it.led_value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        tracker.note_command(it);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: decide ready at the falling edge, sample at the rising edge.
    // Stall in random bursts, once for a long stretch so the command queue
    // fills and the request side stalls.
    // ------------------------------------------------------------------------
    initial
    begin
        int     stall_left;
        logic   long_done;
        reply_t got;
        stall_left   = 0;
        long_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !long_done)
            begin
                stall_left = LONG_HOLD_CYCLES;
                long_done  = 1'b1;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 10)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.read_char         = rsp_ch.read_char;
                got.char_valid        = rsp_ch.char_valid;
                got.data_available    = rsp_ch.data_available;
                got.led_state         = rsp_ch.led_state;
                got.current_modifiers = rsp_ch.current_modifiers;
                got.char_dropped      = rsp_ch.char_dropped;
                tracker.check_reply(got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when nothing moves on either channel for too long.
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else if (rst_n)
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_boot_keyboard_report_to_ascii_unit: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        tracker       = new();
        calm          = 1'b0;
        long_hold_req = 1'b0;
        foreach (held_keys[s]) held_keys[s] = USAGE_NONE;

        // Drive every input to a known value while reset is held, then release reset.
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.command       = CMD_REPORT;
        req_ch.report_length = 7'd0;
        req_ch.modifier_bits = 8'h00;
        req_ch.key_0         = 8'h00;
        req_ch.key_1         = 8'h00;
        req_ch.key_2         = 8'h00;
        req_ch.key_3         = 8'h00;
        req_ch.key_4         = 8'h00;
        req_ch.key_5         = 8'h00;
        req_ch.led_value     = 8'h00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        // Read an empty FIFO; then the unused command with every field at its top.
        offer(make_item(CMD_READ, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                        8'hFF));
        offer(make_item(CMD_UNUSED, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                        8'hFF));
        // Short reports: nothing latched, previous keys kept.
        offer(make_item(CMD_REPORT, 7'd7, 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,
                        8'h00));
        offer(make_item(CMD_REPORT, 7'd0, 8'h22, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'hFF));
        // Minimum length; skip empty and rollover slots.
        offer(make_item(CMD_REPORT, 7'd8, 8'h00, 8'h04, 8'h05, 8'h00, 8'h01, 8'h1D, 8'h27,
                        8'hFF));
        offer(make_item(CMD_READ, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h00));
        // Left shift; a held key; codes at and above 128.
        offer(make_item(CMD_REPORT, 7'd64, 8'h02, 8'h04, 8'h1E, 8'h2D, 8'h38, 8'h80, 8'hFF,
                        8'h00));
        // Right shift; caps lock first, so the letter after it flips back to lower.
        offer(make_item(CMD_REPORT, 7'd127, 8'h20, CAPS_USAGE, 8'h05, 8'h1F, 8'h00, 8'h00,
                        8'h00, 8'h00));
        // Caps held (no toggle); the same new code twice counts twice.
        offer(make_item(CMD_REPORT, 7'd8, 8'h00, CAPS_USAGE, 8'h05, 8'h06, 8'h06, 8'h00,
                        8'h00, 8'h00));
        // Release all keys, then press caps lock twice in one report.
        offer(make_item(CMD_REPORT, 7'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h00));
        offer(make_item(CMD_REPORT, 7'd8, 8'hDD, CAPS_USAGE, CAPS_USAGE, 8'h07, 8'h00,
                        8'h00, 8'h00, 8'h00));
        // LED byte extremes.
        offer(make_item(CMD_SET, 7'd8, 8'hFF, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04,
                        8'hFF));
        offer(make_item(CMD_SET, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h00));
        // Keypad, control characters and punctuation, including the gap at 0x32.
        offer(make_item(CMD_REPORT, 7'd8, 8'h00, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
                        8'h00));
        offer(make_item(CMD_REPORT, 7'd8, 8'h00, 8'h61, 8'h62, 8'h63, 8'h28, 8'h29, 8'h2A,
                        8'h00));
        offer(make_item(CMD_REPORT, 7'd8, 8'h22, 8'h2B, 8'h2C, 8'h31, 8'h32, 8'h34, 8'h35,
                        8'h00));
        offer(make_item(CMD_REPORT, 7'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h00));
        repeat (3)
            offer(make_item(CMD_READ, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                            8'h00, 8'h00));

        // --- random part ---
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
            if (i == LONG_HOLD_AT)
                long_hold_req = 1'b1;
            if (i == DRAIN_AT)
            begin
                // Pause the sender until every owed reply has arrived.
                @(negedge clk);
                req_ch.valid <= 1'b0;
                while (tracker.outstanding() != 0)
                    @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 99) < 15)
            begin
                gap = $urandom_range(1, 16);
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            offer(random_item(i));
        end

        // Drop valid, wait for the last replies, then let the block settle.
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("tb_boot_keyboard_report_to_ascii_unit: clean");
        else
            $display("tb_boot_keyboard_report_to_ascii_unit: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bkra_pkg.sv
sv/bkra_if.sv
sv/bkra_front.sv
sv/bkra_queue.sv
sv/bkra_back.sv
sv/boot_keyboard_report_to_ascii_unit.sv
tb/sv/tb_boot_keyboard_report_to_ascii_unit.sv
